// ----- rtl/mla_pkg.sv -----
// Shared types, constants and a helper function of the modified-Laplacian autofocus block.
`default_nettype none

package mla_pkg;

  // Default size limits of the analysed region.
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
  localparam int FRAME_WIDTH_RST  = 620;
  localparam int FRAME_HEIGHT_RST = 630;
  localparam int MIN_DIM = 3;

  // Fixed-point luma weights, scaled by 2^14, with rounding offset.
  localparam int PROD_W = 22;
  localparam int GSUM_W = 23;
  localparam logic [13:0] COEF_B = 14'd1868;
  localparam logic [13:0] COEF_G = 14'd9617;
  localparam logic [13:0] COEF_R = 14'd4899;
  localparam logic [GSUM_W-1:0] GRAY_ROUND = 23'd8192;
  localparam int GRAY_SHIFT = 14;

  // One second difference is at most 510, four of them at most 2040.
  localparam int DIFF_W = 9;
  localparam int TERM_W = 11;

  // Result word layout.
  localparam int SUM_W  = 32;
  localparam int IDX_W  = 16;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 104;
  localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;

  // Position of a pixel in its frame, as seen by the datapath.
  typedef struct packed {
    logic col_one;
    logic col_ge2;
    logic col_last;
    logic row_one;
    logic row_ge2;
    logic row_last;
  } pos_t;

  // Per-pixel contribution handed to the accumulator.
  typedef struct packed {
    logic              valid;
    logic              frame_last;
    logic [TERM_W-1:0] term;
  } term_t;

  // Absolute value of 2*centre - a - b.
  function automatic logic [DIFF_W-1:0] second_diff(input logic [7:0] centre,
                                                    input logic [7:0] a,
                                                    input logic [7:0] b);
    logic [DIFF_W-1:0] twice;
    logic [DIFF_W-1:0] pair;
    twice = {centre, 1'b0};
    pair  = {1'b0, a} + {1'b0, b};
    return (twice >= pair) ? (twice - pair) : (pair - twice);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/modified_laplacian_autofocus.sv -----
// Top level of the sum-modified-Laplacian autofocus measure over a pixel stream.
//
//  Channel | Direction | Word contents (lowest bits first)
//  --------+-----------+-----------------------------------------------------------
//  in_     | slave     | blue[7:0], green[15:8], red[23:16]
//  out_    | master    | focus_sum, frame_index, is_new_best, best_sum, best_index
//  cfg_    | slave     | index 0 frame_width, index 1 frame_height (12-bit data)
//
// One pixel is taken per clock while the input is not stalled; the result of a frame is
// offered once its last pixel has passed through weights and line memory read, gray value
// and neighbours, term, and the result register. The line memory has one read and one
// write port per cycle. A second result slot sits behind the output register, so the
// input stalls only when both slots are full and the next frame ends.
// Reset is synchronous; the line memory needs no clearing pass.
`default_nettype none

module modified_laplacian_autofocus #(
  parameter int MAX_WIDTH  = mla_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mla_pkg::MAX_HEIGHT_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [mla_pkg::IN_W-1:0]       in_tdata,   // blue, green, red
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // focus_sum, frame_index, is_new_best, best_sum, best_index, zero fill
  output logic [mla_pkg::OUT_W-1:0]      out_tdata,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [mla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [mla_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int W_RST = (mla_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH :
                         mla_pkg::FRAME_WIDTH_RST;
  localparam int H_RST = (mla_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT :
                         mla_pkg::FRAME_HEIGHT_RST;

  logic                       adv;
  logic                       acc;
  logic                       cfg_wr;
  logic [COL_W-1:0]           w_m1_r;
  logic [ROW_W-1:0]           h_m1_r;
  logic [COL_W-1:0]           col_r;
  logic [ROW_W-1:0]           row_r;
  mla_pkg::pos_t              pos;
  mla_pkg::term_t             term;
  logic                       stall;

  logic [mla_pkg::SUM_W-1:0]  run_sum_r;
  logic [mla_pkg::SUM_W:0]    sum_wide;
  logic [mla_pkg::SUM_W-1:0]  sum_nxt;
  logic [mla_pkg::IDX_W-1:0]  frame_cnt_r;
  logic [mla_pkg::IDX_W-1:0]  idx_nxt;
  logic [mla_pkg::SUM_W-1:0]  best_sum_r;
  logic [mla_pkg::IDX_W-1:0]  best_idx_r;
  logic                       better;
  logic                       load_out;
  logic [mla_pkg::OUT_W-1:0]  word_nxt;
  logic                       out_valid_r;
  logic [mla_pkg::OUT_W-1:0]  out_data_r;
  logic                       skid_valid_r;
  logic [mla_pkg::OUT_W-1:0]  skid_data_r;

  // The pipeline halts only when a frame ends while both result slots are full.
  assign stall     = term.valid && term.frame_last && skid_valid_r;
  assign adv       = !stall;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Frame size registers, held clamped and minus one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= COL_W'(W_RST - 1);
      h_m1_r <= ROW_W'(H_RST - 1);
    end else if (cfg_wr) begin
      case (cfg_index)
        mla_pkg::CFG_FRAME_WIDTH: begin
          if (32'(cfg_data) < mla_pkg::MIN_DIM) begin
            w_m1_r <= COL_W'(mla_pkg::MIN_DIM - 1);
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            w_m1_r <= COL_W'(MAX_WIDTH - 1);
          end else begin
            w_m1_r <= COL_W'(32'(cfg_data) - 1);
          end
        end
        mla_pkg::CFG_FRAME_HEIGHT: begin
          if (32'(cfg_data) < mla_pkg::MIN_DIM) begin
            h_m1_r <= ROW_W'(mla_pkg::MIN_DIM - 1);
          end else if (32'(cfg_data) > MAX_HEIGHT) begin
            h_m1_r <= ROW_W'(MAX_HEIGHT - 1);
          end else begin
            h_m1_r <= ROW_W'(32'(cfg_data) - 1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position of the incoming pixel.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (col_r == w_m1_r) begin
        col_r <= '0;
        row_r <= (row_r == h_m1_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    pos.col_one  = (col_r == COL_W'(1));
    pos.col_ge2  = (col_r >= COL_W'(2));
    pos.col_last = (col_r == w_m1_r);
    pos.row_one  = (row_r == ROW_W'(1));
    pos.row_ge2  = (row_r >= ROW_W'(2));
    pos.row_last = (row_r == h_m1_r);
  end

  mla_lap_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .acc      (acc),
    .restart  (cfg_wr),
    .blue     (in_tdata[7:0]),
    .green    (in_tdata[15:8]),
    .red      (in_tdata[23:16]),
    .col      (col_r),
    .pos      (pos),
    .term_out (term)
  );

  // Saturating frame sum, next index and best-frame comparison.
  always_comb begin
    sum_wide = {1'b0, run_sum_r} + (mla_pkg::SUM_W + 1)'(term.term);
    sum_nxt  = sum_wide[mla_pkg::SUM_W] ? '1 : sum_wide[mla_pkg::SUM_W-1:0];
    idx_nxt  = (frame_cnt_r == mla_pkg::IDX_MAX) ? mla_pkg::IDX_W'(1) :
               frame_cnt_r + mla_pkg::IDX_W'(1);
    better   = sum_nxt > best_sum_r;
    load_out = term.valid && term.frame_last && adv;
    word_nxt = {7'd0,
                better ? idx_nxt : best_idx_r,
                better ? sum_nxt : best_sum_r,
                better,
                idx_nxt,
                sum_nxt};
  end

  // Accumulator and frame statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r   <= '0;
      frame_cnt_r <= '0;
      best_sum_r  <= '0;
      best_idx_r  <= '0;
    end else if (cfg_wr) begin
      run_sum_r <= '0;
    end else if (term.valid && adv) begin
      if (term.frame_last) begin
        run_sum_r   <= '0;
        frame_cnt_r <= idx_nxt;
        if (better) begin
          best_sum_r <= sum_nxt;
          best_idx_r <= idx_nxt;
        end
      end else begin
        run_sum_r <= sum_nxt;
      end
    end
  end

  // Result register with a second slot behind it; the older word is always in front.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || load_out;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      skid_valid_r <= 1'b1;
    end
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (load_out) begin
        out_data_r <= word_nxt;
      end
    end else if (load_out) begin
      skid_data_r <= word_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/mla_lap_core.sv -----
// Gray conversion, line memory and modified-Laplacian term for each pixel.
`default_nettype none

module mla_lap_core #(
  parameter int MAX_WIDTH = mla_pkg::MAX_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         adv,
  input  wire                         acc,
  input  wire                         restart,
  input  wire  [7:0]                  blue,
  input  wire  [7:0]                  green,
  input  wire  [7:0]                  red,
  input  wire  [$clog2(MAX_WIDTH)-1:0] col,
  input  mla_pkg::pos_t               pos,
  output mla_pkg::term_t              term_out
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // Line memory: upper byte is the row two back, lower byte the row one back.
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd_q_r;

  // Stage 1: weighted channels.
  logic                      s1_valid_r;
  logic [mla_pkg::PROD_W-1:0] s1_pb_r;
  logic [mla_pkg::PROD_W-1:0] s1_pg_r;
  logic [mla_pkg::PROD_W-1:0] s1_pr_r;
  logic [COL_W-1:0]          s1_col_r;
  mla_pkg::pos_t             s1_pos_r;
  logic [mla_pkg::GSUM_W-1:0] s1_gsum;
  logic [7:0]                s1_gray;

  // Stage 2: gray pixel and its vertical neighbours.
  logic                      s2_valid_r;
  logic [7:0]                s2_gray_r;
  logic [7:0]                s2_above_r;
  logic [7:0]                s2_up_r;
  logic [COL_W-1:0]          s2_col_r;
  mla_pkg::pos_t             s2_pos_r;
  logic [7:0]                win0_r;
  logic [7:0]                win1_r;
  logic [mla_pkg::DIFF_W-1:0] h_a;
  logic [mla_pkg::DIFF_W-1:0] h_b;
  logic [mla_pkg::DIFF_W-1:0] v_a;
  logic [mla_pkg::DIFF_W-1:0] v_b;
  logic [mla_pkg::TERM_W-1:0] term_nxt;
  logic                      wr_en;

  // Stage 3: term towards the accumulator.
  mla_pkg::term_t            t_r;

  // Stage 1 registers; the line memory read sits in the block below.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
    end
    if (adv) begin
      s1_pb_r  <= mla_pkg::PROD_W'(blue)  * mla_pkg::PROD_W'(mla_pkg::COEF_B);
      s1_pg_r  <= mla_pkg::PROD_W'(green) * mla_pkg::PROD_W'(mla_pkg::COEF_G);
      s1_pr_r  <= mla_pkg::PROD_W'(red)   * mla_pkg::PROD_W'(mla_pkg::COEF_R);
      s1_col_r <= col;
      s1_pos_r <= pos;
    end
  end

  // Write the column back as the pixel leaves stage 2; a read of the same
  // column comes at least one full row later, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s2_col_r] <= {s2_above_r, s2_gray_r};
    end
    if (acc) begin
      rd_q_r <= line_mem[col];
    end
  end

  // Rounded gray value.
  assign s1_gsum = mla_pkg::GSUM_W'(s1_pb_r) + mla_pkg::GSUM_W'(s1_pg_r) +
                   mla_pkg::GSUM_W'(s1_pr_r) + mla_pkg::GRAY_ROUND;
  assign s1_gray = s1_gsum[mla_pkg::GRAY_SHIFT +: 8];

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      s2_gray_r  <= s1_gray;
      s2_above_r <= rd_q_r[7:0];
      s2_up_r    <= rd_q_r[15:8];
      s2_col_r   <= s1_col_r;
      s2_pos_r   <= s1_pos_r;
    end
  end

  // Horizontal and vertical second differences with mirrored borders.
  always_comb begin
    h_a = '0;
    h_b = '0;
    v_a = '0;
    v_b = '0;
    if (s2_pos_r.col_one) begin
      h_a = mla_pkg::second_diff(win0_r, s2_gray_r, s2_gray_r);
    end else if (s2_pos_r.col_ge2) begin
      h_a = mla_pkg::second_diff(win0_r, win1_r, s2_gray_r);
    end
    if (s2_pos_r.col_last) begin
      h_b = mla_pkg::second_diff(s2_gray_r, win0_r, win0_r);
    end
    if (s2_pos_r.row_one) begin
      v_a = mla_pkg::second_diff(s2_above_r, s2_gray_r, s2_gray_r);
    end else if (s2_pos_r.row_ge2) begin
      v_a = mla_pkg::second_diff(s2_above_r, s2_up_r, s2_gray_r);
    end
    if (s2_pos_r.row_last) begin
      v_b = mla_pkg::second_diff(s2_gray_r, s2_above_r, s2_above_r);
    end
    term_nxt = mla_pkg::TERM_W'(h_a) + mla_pkg::TERM_W'(h_b) +
               mla_pkg::TERM_W'(v_a) + mla_pkg::TERM_W'(v_b);
  end

  assign wr_en = s2_valid_r && adv;

  // Two-pixel window of the current row, emptied at the end of each row.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win0_r <= '0;
      win1_r <= '0;
    end else if (wr_en) begin
      if (s2_pos_r.col_last) begin
        win0_r <= '0;
        win1_r <= '0;
      end else begin
        win0_r <= s2_gray_r;
        win1_r <= win0_r;
      end
    end
  end

  // Stage 3 register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r.valid <= 1'b0;
    end else if (adv) begin
      t_r.valid <= s2_valid_r;
    end
    if (adv) begin
      t_r.frame_last <= s2_pos_r.col_last && s2_pos_r.row_last;
      t_r.term       <= term_nxt;
    end
  end

  assign term_out = t_r;

endmodule

`default_nettype wire

// ----- rtl/mla_checker.sv -----
// Port-level checks of the autofocus result stream, bound to the top level.
`default_nettype none

module mla_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       out_tvalid,
  input wire                       out_tready,
  input wire [mla_pkg::OUT_W-1:0]  out_tdata
);

  logic [31:0] focus_sum;
  logic [15:0] frame_index;
  logic        is_new_best;
  logic [31:0] best_sum;
  logic [15:0] best_index;

  assign focus_sum   = out_tdata[31:0];
  assign frame_index = out_tdata[47:32];
  assign is_new_best = out_tdata[48];
  assign best_sum    = out_tdata[80:49];
  assign best_index  = out_tdata[96:81];

  // A held word stays offered and unchanged.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // The best sum can never be below the frame just reported.
  a_best_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> best_sum >= focus_sum)
    else $error("best sum below current frame sum");

  // A new best must be the reported frame itself.
  a_new_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && is_new_best |-> best_index == frame_index && best_sum == focus_sum)
    else $error("new best does not match current frame");

  // Frame indexes start at one and skip zero on wrap.
  a_index_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> frame_index != 16'd0)
    else $error("frame index zero");

endmodule

bind modified_laplacian_autofocus mla_checker u_mla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
